/* design/adaptive_flow_priority_classifier_core_defines.svh */
// Assertion macros for the adaptive flow priority classifier.
// No dependencies; included by the top level.
`ifndef ADAPTIVE_FLOW_PRIORITY_CLASSIFIER_CORE_DEFINES_SVH
`define ADAPTIVE_FLOW_PRIORITY_CLASSIFIER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define AFPC_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define AFPC_ASSERT_RESET(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define AFPC_ASSERT_IMPL(label, clk, rst_n, prop)
`define AFPC_ASSERT_RESET(label, clk, prop)
`endif
`endif

/* design/afpc_pkg.sv */
// Package for the adaptive flow priority classifier: item types, register
// map, sequencer states and constants. No dependencies.
`default_nettype none
package afpc_pkg;
	typedef struct packed {
		logic        tracked;
		logic [31:0] sent_total;
		logic [15:0] pay_len;
	} afpc_in_t;

	typedef struct packed {
		logic [2:0] priority_res;
		logic [2:0] dscp;
		logic       stats_updated;
	} afpc_out_t;

	localparam logic [1:0] REG_LARGE_MIN = 2'd0;
	localparam logic [1:0] REG_SEG_BYTES = 2'd1;
	localparam logic [1:0] REG_AGING     = 2'd2;

	localparam logic [15:0] LARGE_MIN_RST = 16'd1400;
	localparam logic [15:0] SEG_BYTES_RST = 16'd1500;
	localparam logic [11:0] AGING_RST     = 12'd2560;
	localparam logic [2:0]  DSCP_TOP      = 3'd7;

	localparam logic [47:0] SUM_MAX   = 48'hFFFF_FFFF_FFFF;
	localparam logic [11:0] COUNT_MAX = 12'hFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_DIV_DONE,
		ST_MUL,
		ST_SQRT_RUN,
		ST_CMP,
		ST_SEG_RUN,
		ST_UPD_MUL,
		ST_UPD_WRITE,
		ST_OUT
	} afpc_state_t;
endpackage
`default_nettype wire

/* design/adaptive_flow_priority_classifier_core.sv */
// Adaptive flow priority classifier: one item in, one item out, one item in work at a time.
// Untracked or small items go straight to the output. A tracked large item first forms the average
// of queue 0, then for each further step a divide, a multiply and a square root, and last counts its
// segments; when queue 0 is empty it goes straight to segment counting.
// in_stall is high until the result is taken, so a new item is accepted only after the last result.
// arst_n clears the queue statistics, registers to their defaults and the sequencer at once.
`default_nettype none
`include "adaptive_flow_priority_classifier_core_defines.svh"
module adaptive_flow_priority_classifier_core
	import afpc_pkg::*;
#(
	parameter int NUM_QUEUES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire afpc_in_t    in_data,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      afpc_out_t   out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);
	localparam int QW = $clog2(NUM_QUEUES);

	// Statistics, one entry per queue, held in flip-flops so reset clears them.
	logic [47:0] sum_q [NUM_QUEUES];
	logic [11:0] cnt_q [NUM_QUEUES];

	logic [15:0] large_min_q, seg_bytes_q;
	logic [11:0] aging_q;

	afpc_state_t state_q, state_d;
	afpc_in_t    item_q;
	afpc_out_t   res_q;
	logic [QW-1:0] idx_q;        // queue whose average is being formed
	logic [QW-1:0] choice_q;
	logic        first_q;       // average of queue 0 in progress
	logic [63:0] cur_q, nxt_q;  // averages of queues i and i+1

	// Shared restoring divider / square root datapath.
	logic [63:0] num_q;         // dividend shifting into remainder, or radicand
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [6:0]  step_q;
	logic [63:0] rem_sh, rem_sub;
	logic        rem_ge;

	// Shared 32 x 32 multiplier.
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	logic        apb_wr;
	logic        item_acc, res_acc;
	logic        div_last, sqrt_last, seg_last;

	assign pready   = 1'b1;
	assign apb_wr   = psel && penable && pwrite;
	assign item_acc = in_valid && !in_stall;
	assign res_acc  = out_valid && !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = res_q;

	always_comb begin
		case (paddr[3:2])
			REG_LARGE_MIN: prdata = {16'd0, large_min_q};
			REG_SEG_BYTES: prdata = {16'd0, seg_bytes_q};
			REG_AGING:     prdata = {20'd0, aging_q};
			default:       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			large_min_q <= LARGE_MIN_RST;
			seg_bytes_q <= SEG_BYTES_RST;
			aging_q     <= AGING_RST;
		end else if (apb_wr) begin
			case (paddr[3:2])
				REG_LARGE_MIN: large_min_q <= pwdata[15:0];
				REG_SEG_BYTES: seg_bytes_q <= pwdata[15:0];
				REG_AGING:     aging_q     <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// One restoring step: remainder shifted left by one bit of the numerator,
	// then a trial subtract of the divisor. The square root uses the same
	// subtractor with a trial value of {root, 01}, two radicand bits a step.
	always_comb begin
		if (state_q == ST_SQRT_RUN) begin
			rem_sh  = {rem_q[61:0], num_q[63:62]};
			rem_sub = rem_sh - {quo_q[61:0], 2'b01};
			rem_ge  = (rem_sh >= {quo_q[61:0], 2'b01});
		end else begin
			rem_sh  = {rem_q[62:0], num_q[63]};
			rem_sub = rem_sh - den_q;
			rem_ge  = (rem_sh >= den_q);
		end
	end

	assign div_last  = (step_q == 7'd63);
	assign sqrt_last = (step_q == 7'd31);
	assign seg_last  = (step_q == 7'd15);

	// Segment count and weighted bytes.
	logic [15:0] seg_eff;
	logic [15:0] k_next;
	logic [15:0] k_q;
	logic [47:0] wsum_s1;
	logic [16:0] cnt_new;
	logic [48:0] sum_new;
	logic [16:0] cnt_aged;
	logic [48:0] sum_aged;
	assign seg_eff = (seg_bytes_q == 16'd0) ? 16'd1 : seg_bytes_q;
	assign k_next  = (item_q.pay_len == 16'd0) ? 16'd0 :
		(item_q.pay_len > seg_eff) ? 16'd1 + quo_q[15:0] : 16'd1;

	// The product of the two averages is formed low half first, then the two
	// cross terms that land in the upper word. The same multiplier weights the
	// bytes by the segment count before the update.
	always_comb begin
		if (state_q == ST_UPD_MUL) begin
			mul_a = item_q.sent_total;
			mul_b = {16'd0, k_next};
		end else begin
			case (step_q[1:0])
				2'd1: begin
					mul_a = cur_q[63:32];
					mul_b = nxt_q[31:0];
				end
				2'd2: begin
					mul_a = cur_q[31:0];
					mul_b = nxt_q[63:32];
				end
				default: begin
					mul_a = cur_q[31:0];
					mul_b = nxt_q[31:0];
				end
			endcase
		end
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		cnt_new = {5'd0, cnt_q[choice_q]} + {1'b0, k_q};
		sum_new = {1'b0, sum_q[choice_q]} + {1'b0, wsum_s1};
		if (cnt_new > {5'd0, aging_q}) begin
			cnt_aged = cnt_new >> 1;
			sum_aged = sum_new >> 1;
		end else begin
			cnt_aged = cnt_new;
			sum_aged = sum_new;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (item_acc) begin
					if (!in_data.tracked || in_data.pay_len < large_min_q)
						state_d = ST_OUT;
					else if (cnt_q[0] == 12'd0)
						state_d = ST_SEG_RUN;
					else
						state_d = ST_DIV_START;
				end
			ST_DIV_START: state_d = ST_DIV_RUN;
			ST_DIV_RUN:   if (div_last) state_d = ST_DIV_DONE;
			ST_DIV_DONE: begin
				if (first_q) begin
					if (quo_q == 64'd0 || NUM_QUEUES < 2)
						state_d = ST_SEG_RUN;
					else if (cnt_q[idx_q + QW'(1)] == 12'd0)
						state_d = ST_SEG_RUN;
					else
						state_d = ST_DIV_START;
				end else if (quo_q <= cur_q)
					state_d = ST_SEG_RUN;
				else
					state_d = ST_MUL;
			end
			ST_MUL:      if (step_q == 7'd2) state_d = ST_SQRT_RUN;
			ST_SQRT_RUN: if (sqrt_last) state_d = ST_CMP;
			ST_CMP: begin
				if (item_q.sent_total <= quo_q[31:0] || quo_q[63:32] != 32'd0)
					state_d = ST_SEG_RUN;
				else if (32'(idx_q) == NUM_QUEUES - 1)
					state_d = ST_SEG_RUN;
				else if (cnt_q[idx_q + QW'(1)] == 12'd0)
					state_d = ST_SEG_RUN;
				else
					state_d = ST_DIV_START;
			end
			ST_SEG_RUN:   if (seg_last) state_d = ST_UPD_MUL;
			ST_UPD_MUL:   state_d = ST_UPD_WRITE;
			ST_UPD_WRITE: state_d = ST_OUT;
			ST_OUT:       if (res_acc) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Datapath and choice tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			item_q   <= '0;
			res_q    <= '0;
			idx_q    <= '0;
			choice_q <= '0;
			first_q  <= 1'b0;
			cur_q    <= '0;
			nxt_q    <= '0;
			num_q    <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			den_q    <= '0;
			step_q   <= '0;
			k_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (item_acc) begin
					item_q   <= in_data;
					idx_q    <= '0;
					choice_q <= '0;
					first_q  <= 1'b1;
					res_q    <= '{priority_res: 3'd0, dscp: DSCP_TOP, stats_updated: 1'b0};
					// segment divider set up for the empty-first-queue case
					num_q  <= {in_data.pay_len - 16'd1, 48'd0};
					rem_q  <= '0;
					quo_q  <= '0;
					den_q  <= 64'(seg_bytes_q == 16'd0 ? 16'd1 : seg_bytes_q);
					step_q <= '0;
				end
				ST_DIV_START: begin
					num_q  <= 64'(sum_q[idx_q]);
					den_q  <= 64'(cnt_q[idx_q]);
					rem_q  <= '0;
					quo_q  <= '0;
					step_q <= '0;
				end
				ST_DIV_RUN: begin
					num_q  <= {num_q[62:0], 1'b0};
					rem_q  <= rem_ge ? rem_sub : rem_sh;
					quo_q  <= {quo_q[62:0], rem_ge};
					step_q <= step_q + 7'd1;
				end
				ST_DIV_DONE: begin
					if (first_q) begin
						cur_q   <= quo_q;
						first_q <= 1'b0;
						if (quo_q == 64'd0)
							choice_q <= '0;
						else
							choice_q <= idx_q + QW'(1);
						idx_q <= idx_q + QW'(1);
					end else begin
						nxt_q    <= quo_q;
						choice_q <= idx_q;
					end
					step_q <= '0;
					// Load the segment divider when the search ends here.
					if (state_d == ST_SEG_RUN) begin
						num_q <= {item_q.pay_len - 16'd1, 48'd0};
						rem_q <= '0;
						quo_q <= '0;
						den_q <= 64'(seg_eff);
					end
				end
				ST_MUL: begin
					if (step_q == 7'd0)
						num_q <= mul_p;
					else
						num_q <= num_q + {mul_p[31:0], 32'd0};
					if (step_q == 7'd2) begin
						rem_q  <= '0;
						quo_q  <= '0;
						step_q <= '0;
					end else
						step_q <= step_q + 7'd1;
				end
				ST_SQRT_RUN: begin
					num_q  <= {num_q[61:0], 2'b00};
					rem_q  <= rem_ge ? rem_sub : rem_sh;
					quo_q  <= {quo_q[62:0], rem_ge};
					step_q <= step_q + 7'd1;
				end
				ST_CMP: begin
					if (item_q.sent_total <= quo_q[31:0] || quo_q[63:32] != 32'd0)
						choice_q <= idx_q - QW'(1);
					else if (32'(idx_q) == NUM_QUEUES - 1)
						choice_q <= idx_q;
					else begin
						cur_q    <= nxt_q;
						choice_q <= idx_q + QW'(1);
						idx_q    <= idx_q + QW'(1);
					end
					// Load the segment divider when the search ends here.
					if (state_d == ST_SEG_RUN) begin
						num_q  <= {item_q.pay_len - 16'd1, 48'd0};
						rem_q  <= '0;
						quo_q  <= '0;
						den_q  <= 64'(seg_eff);
						step_q <= '0;
					end
				end
				ST_SEG_RUN: begin
					num_q  <= {num_q[62:0], 1'b0};
					rem_q  <= rem_ge ? rem_sub : rem_sh;
					quo_q  <= {quo_q[62:0], rem_ge};
					step_q <= step_q + 7'd1;
				end
				ST_UPD_MUL: k_q <= k_next;
				ST_UPD_WRITE: begin
					cnt_q[choice_q] <= (cnt_aged > {5'd0, COUNT_MAX}) ? COUNT_MAX
						: cnt_aged[11:0];
					sum_q[choice_q] <= (sum_aged > {1'b0, SUM_MAX}) ? SUM_MAX
						: sum_aged[47:0];
					res_q <= '{priority_res: 3'(choice_q), dscp: DSCP_TOP - 3'(choice_q),
						stats_updated: 1'b1};
				end
				default: ;
			endcase
		end
	end

	// Weighted bytes: a 32 x 16 product from the shared multiplier, registered
	// before the update.
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD_MUL)
			wsum_s1 <= mul_p[47:0];
	end

	`AFPC_ASSERT_IMPL(a_stall_busy, clk, arst_n, (state_q != ST_IDLE) |-> in_stall)
	`AFPC_ASSERT_IMPL(a_dscp, clk, arst_n, out_valid |-> (out_data.dscp == DSCP_TOP - out_data.priority_res))
	`AFPC_ASSERT_IMPL(a_untouched, clk, arst_n, (out_valid && !out_data.stats_updated) |-> (out_data.priority_res == 3'd0))
	`AFPC_ASSERT_RESET(a_reset_idle, clk, !arst_n |=> !out_valid)
endmodule
`default_nettype wire

/* tb/tb_adaptive_flow_priority_classifier_core.sv */
// Self-checking bench for the adaptive flow priority classifier core.
// Depends on afpc_pkg and the core; drives items, APB writes and checks every result.
`timescale 1ns / 100ps
`default_nettype none
module tb_adaptive_flow_priority_classifier_core;
	import afpc_pkg::*;

	localparam int QUEUES = 8;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	afpc_in_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	afpc_out_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Register offsets: one 32-bit word per register.
	localparam logic [3:0] ADDR_LARGE_MIN = {REG_LARGE_MIN, 2'b00};
	localparam logic [3:0] ADDR_SEG_BYTES = {REG_SEG_BYTES, 2'b00};
	localparam logic [3:0] ADDR_AGING     = {REG_AGING, 2'b00};

	adaptive_flow_priority_classifier_core #(.NUM_QUEUES(QUEUES)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// The bench's own copy of the queue statistics and register settings.
	logic [47:0] q_sum [QUEUES];
	logic [11:0] q_cnt [QUEUES];
	logic [15:0] thr_large;
	logic [15:0] seg_size;
	logic [11:0] age_lim;

	afpc_in_t  pending_items [$];
	afpc_out_t expected_marks [$];

	int  errors = 0;
	int  n_items = 0;
	int  n_results = 0;
	int  n_updates = 0;
	bit  hold_rx = 1'b0;
	bit  timed_out = 1'b0;
	int  tx_wait = 0;
	int  rx_wait = 0;
	int  idle_cycles = 0;

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] y;
		logic [63:0] m;
		logic [63:0] b;
		y = '0;
		m = 64'd1 << 62;
		while (m > x)
			m = m >> 2;
		while (m != 0) begin
			b = y + m;
			y = y >> 1;
			if (x >= b) begin
				x = x - b;
				y = y + m;
			end
			m = m >> 2;
		end
		return y;
	endfunction

	function automatic int pick_queue(input logic [31:0] sent);
		logic [63:0] cur;
		logic [63:0] nxt;
		logic [63:0] prod;
		if (q_cnt[0] == 0)
			return 0;
		cur = {16'd0, q_sum[0]} / q_cnt[0];
		if (cur == 0)
			return 0;
		for (int i = 0; i + 1 < QUEUES; i++) begin
			if (q_cnt[i+1] == 0)
				return i + 1;
			nxt = {16'd0, q_sum[i+1]} / q_cnt[i+1];
			if (nxt <= cur)
				return i + 1;
			prod = cur * nxt;
			if ({32'd0, sent} <= root64(prod))
				return i;
			cur = nxt;
		end
		return QUEUES - 1;
	endfunction

	// Classifies one item and applies its statistics update.
	function automatic afpc_out_t classify(input afpc_in_t it);
		afpc_out_t r;
		int q;
		logic [31:0] seg;
		logic [31:0] k;
		logic [31:0] cnt;
		logic [63:0] sum;
		r = '0;
		if (it.tracked) begin
			q = pick_queue(it.sent_total);
			if (it.pay_len >= thr_large) begin
				seg = (seg_size == 0) ? 32'd1 : {16'd0, seg_size};
				k = (it.pay_len > 0) ? 32'd1 : 32'd0;
				if ({16'd0, it.pay_len} > seg)
					k = k + ({16'd0, it.pay_len} - 1) / seg;
				cnt = q_cnt[q] + k;
				sum = {16'd0, q_sum[q]} + {32'd0, it.sent_total} * {32'd0, k};
				if (cnt > age_lim) begin
					cnt = cnt >> 1;
					sum = sum >> 1;
				end
				if (cnt > COUNT_MAX)
					cnt = COUNT_MAX;
				if (sum > {16'd0, SUM_MAX})
					sum = {16'd0, SUM_MAX};
				q_cnt[q] = cnt[11:0];
				q_sum[q] = sum[47:0];
				r.priority_res = q[2:0];
				r.stats_updated = 1'b1;
			end
		end
		r.dscp = DSCP_TOP - r.priority_res;
		return r;
	endfunction

	// Driver: offers queued items one at a time, with a random gap before each.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_marks.push_back(classify(in_data));
				n_items++;
				in_valid <= 1'b0;
				tx_wait = $urandom_range(0, 3);
			end else if (!in_valid) begin
				if (tx_wait > 0)
					tx_wait--;
				else if (pending_items.size() > 0) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
				end
			end
		end
	end

	// Monitor: compares each accepted result and draws the next stall pattern.
	// The drawn wait is counted only while a result is on offer.
	always @(posedge clk) begin
		afpc_out_t exp_r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_marks.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					errors++;
				end else begin
					exp_r = expected_marks.pop_front();
					if (out_data.stats_updated) n_updates++;
					if (out_data.priority_res !== exp_r.priority_res) begin
						$display("%0t: priority expected %0d actual %0d", $time,
							exp_r.priority_res, out_data.priority_res);
						errors++;
					end
					if (out_data.dscp !== exp_r.dscp) begin
						$display("%0t: dscp expected %0d actual %0d", $time,
							exp_r.dscp, out_data.dscp);
						errors++;
					end
					if (out_data.stats_updated !== exp_r.stats_updated) begin
						$display("%0t: stats_updated expected %0d actual %0d", $time,
							exp_r.stats_updated, out_data.stats_updated);
						errors++;
					end
				end
				rx_wait = $urandom_range(0, 3);
			end
			if (hold_rx)
				out_stall <= 1'b1;
			else if (rx_wait > 0) begin
				if (out_valid)
					rx_wait--;
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// Watchdog: counts cycles in which neither channel accepts an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
				timed_out = 1'b1;
				$display("adaptive_flow_priority_classifier_core: mismatch");
				$finish;
			end
		end
	end

	// APB write: setup cycle then access cycle; the model takes the value too.
	task automatic reg_write(input logic [3:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (addr)
			ADDR_LARGE_MIN: thr_large = value[15:0];
			ADDR_SEG_BYTES: seg_size = value[15:0];
			ADDR_AGING:     age_lim = value[11:0];
			default: ;
		endcase
	endtask

	// Waits until every queued item is sent and every result has arrived.
	// Checked at the falling edge, once the driver's updates have settled.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_marks.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic afpc_in_t make_item(input bit trk, input logic [31:0] sent,
		input logic [15:0] plen);
		afpc_in_t it;
		it.tracked = trk;
		it.sent_total = sent;
		it.pay_len = plen;
		return it;
	endfunction

	// Mostly large tracked packets whose byte counts are spread over decades,
	// so that the queue averages rise and the boundary search goes deep.
	function automatic afpc_in_t random_item();
		logic [31:0] sent;
		int sel;
		sel = $urandom_range(0, 9);
		sent = $urandom() >> $urandom_range(0, 31);
		if (sel < 7)
			return make_item(1'b1, sent, 16'(thr_large + $urandom_range(0, 3000)));
		else if (sel < 9)
			return make_item(1'b1, sent, 16'($urandom()));
		else
			return make_item(1'b0, $urandom(), 16'($urandom()));
	endfunction

	initial begin
		for (int i = 0; i < QUEUES; i++) begin
			q_sum[i] = '0;
			q_cnt[i] = '0;
		end
		thr_large = LARGE_MIN_RST;
		seg_size = SEG_BYTES_RST;
		age_lim = AGING_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: untracked and small items, field extremes, rising averages.
		pending_items.push_back(make_item(1'b0, 32'hFFFF_FFFF, 16'hFFFF));
		pending_items.push_back(make_item(1'b1, 32'd0, 16'd0));
		pending_items.push_back(make_item(1'b1, 32'd5, 16'd1399));
		pending_items.push_back(make_item(1'b1, 32'd0, 16'd1400));
		pending_items.push_back(make_item(1'b1, 32'd100, 16'd1400));
		pending_items.push_back(make_item(1'b1, 32'd1000, 16'd1500));
		pending_items.push_back(make_item(1'b1, 32'd10000, 16'd1501));
		pending_items.push_back(make_item(1'b1, 32'd100000, 16'd3001));
		pending_items.push_back(make_item(1'b1, 32'd1000000, 16'hFFFF));
		pending_items.push_back(make_item(1'b1, 32'd10000000, 16'd2000));
		pending_items.push_back(make_item(1'b1, 32'hFFFF_FFFF, 16'hFFFF));
		pending_items.push_back(make_item(1'b1, 32'd50, 16'd1400));
		pending_items.push_back(make_item(1'b1, 32'd50000, 16'd1400));
		drain();

		// Zero threshold with zero payload, zero segment size and an aging limit
		// of one, so that saturation and halving both occur.
		reg_write(ADDR_LARGE_MIN, 32'd0);
		reg_write(ADDR_SEG_BYTES, 32'd0);
		reg_write(ADDR_AGING, 32'd1);
		pending_items.push_back(make_item(1'b1, 32'd7, 16'd0));
		pending_items.push_back(make_item(1'b1, 32'hFFFF_FFFF, 16'hFFFF));
		pending_items.push_back(make_item(1'b1, 32'hFFFF_FFFF, 16'hFFFF));
		pending_items.push_back(make_item(1'b1, 32'd3, 16'd1));
		drain();

		// Largest settings, then the sender pauses until everything has come.
		reg_write(ADDR_LARGE_MIN, 32'hFFFF);
		reg_write(ADDR_SEG_BYTES, 32'hFFFF);
		reg_write(ADDR_AGING, 32'hFFF);
		pending_items.push_back(make_item(1'b1, 32'hAAAA_5555, 16'hFFFF));
		pending_items.push_back(make_item(1'b1, 32'h5555_AAAA, 16'hFFFE));
		drain();

		// Random phases over several settings; one phase holds the receiver off.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					reg_write(ADDR_LARGE_MIN, 32'd1400);
					reg_write(ADDR_SEG_BYTES, 32'd1500);
					reg_write(ADDR_AGING, 32'd2560);
				end
				1: begin
					reg_write(ADDR_LARGE_MIN, $urandom_range(0, 2000));
					reg_write(ADDR_SEG_BYTES, $urandom_range(1, 4000));
					reg_write(ADDR_AGING, $urandom_range(1, 64));
				end
				2: begin
					reg_write(ADDR_LARGE_MIN, 32'd64);
					reg_write(ADDR_SEG_BYTES, 32'd1);
					reg_write(ADDR_AGING, 32'd4095);
				end
				default: begin
					reg_write(ADDR_LARGE_MIN, $urandom_range(0, 65535));
					reg_write(ADDR_SEG_BYTES, $urandom_range(1, 65535));
					reg_write(ADDR_AGING, $urandom_range(1, 4095));
				end
			endcase
			for (int n = 0; n < 145; n++)
				pending_items.push_back(random_item());
			if (ph == 1) begin
				hold_rx = 1'b1;
				repeat (3000) @(posedge clk);
				hold_rx = 1'b0;
			end
			drain();
		end

		wait (expected_marks.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d items, %0d results, %0d statistics updates", n_items,
			n_results, n_updates);
		$display("over reset, extreme and random register settings.");
		if (errors == 0 && expected_marks.size() == 0)
			$display("adaptive_flow_priority_classifier_core: match");
		else
			$display("adaptive_flow_priority_classifier_core: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
+incdir+design
design/afpc_pkg.sv
design/adaptive_flow_priority_classifier_core.sv
tb/tb_adaptive_flow_priority_classifier_core.sv
